// File: hdl/grid_cursor_and_route_cost_core_assert.svh
// Assertion macros shared by the grid cursor and route cost core.
`ifndef GRID_CURSOR_AND_ROUTE_COST_CORE_ASSERT_SVH
`define GRID_CURSOR_AND_ROUTE_COST_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define GCRC_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define GCRC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hdl/gcrc_pkg.sv
// Shared types and constants for the grid cursor and route cost core.
`timescale 1ns / 1ps
`default_nettype none

package gcrc_pkg;

  // Field and internal widths
  localparam int CoordW   = 13;  // cursor column / row, covers any clamped size
  localparam int LayerW   = 4;   // cursor layer, covers any clamped layer count
  localparam int SizeW    = 13;
  localparam int SizeZW   = 4;
  localparam int WeightW  = 8;
  localparam int IndexW   = 27;
  localparam int CostW    = 21;
  localparam int CostSumW = 23;
  localparam int AddrW    = 3;

  // Opcodes
  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_STEP_X = 3'd1;
  localparam logic [2:0] OP_STEP_Y = 3'd2;
  localparam logic [2:0] OP_STEP_Z = 3'd3;
  localparam logic [2:0] OP_DIST   = 3'd4;

  // Register indexes
  localparam logic [AddrW-1:0] REG_SIZE_X     = 3'd0;
  localparam logic [AddrW-1:0] REG_SIZE_Y     = 3'd1;
  localparam logic [AddrW-1:0] REG_SIZE_Z     = 3'd2;
  localparam logic [AddrW-1:0] REG_COST_X     = 3'd3;
  localparam logic [AddrW-1:0] REG_COST_Y     = 3'd4;
  localparam logic [AddrW-1:0] REG_COST_LAYER = 3'd5;

  localparam logic [CostW-1:0] COST_SAT = {CostW{1'b1}};

  // Clamped sizes and weights as seen by the datapath
  typedef struct packed {
    logic [SizeW-1:0]   ex;
    logic [SizeW-1:0]   ey;
    logic [SizeZW-1:0]  ez;
    logic [WeightW-1:0] cost_x;
    logic [WeightW-1:0] cost_y;
    logic [WeightW-1:0] cost_layer;
  } grid_cfg_t;

  // Item handed from the cursor stage to the result stages
  typedef struct packed {
    logic              live;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [LayerW-1:0] layer;
    logic              has_cost;
    logic              err;
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
    logic [LayerW-1:0] dz;
    logic [1:0]        vias;
  } cur_item_t;

endpackage

`default_nettype wire

// File: hdl/gcrc_cfg_regs.sv
// Configuration registers and size clamping.
`timescale 1ns / 1ps
`default_nettype none

module gcrc_cfg_regs #(
  parameter int MAX_COLS   = 4096,
  parameter int MAX_ROWS   = 4096,
  parameter int MAX_LAYERS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [gcrc_pkg::AddrW-1:0]    cfg_addr,
  input  wire logic [gcrc_pkg::SizeW-1:0]    cfg_data,
  output gcrc_pkg::grid_cfg_t                cfg
);
  import gcrc_pkg::*;

  logic [SizeW-1:0]   size_x;
  logic [SizeW-1:0]   size_y;
  logic [SizeZW-1:0]  size_z;
  logic [WeightW-1:0] cost_x;
  logic [WeightW-1:0] cost_y;
  logic [WeightW-1:0] cost_layer;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= 13'd4096;
      size_y     <= 13'd4096;
      size_z     <= 4'd8;
      cost_x     <= 8'd1;
      cost_y     <= 8'd1;
      cost_layer <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SIZE_X:     size_x     <= cfg_data;
        REG_SIZE_Y:     size_y     <= cfg_data;
        REG_SIZE_Z:     size_z     <= cfg_data[SizeZW-1:0];
        REG_COST_X:     cost_x     <= cfg_data[WeightW-1:0];
        REG_COST_Y:     cost_y     <= cfg_data[WeightW-1:0];
        REG_COST_LAYER: cost_layer <= cfg_data[WeightW-1:0];
        default: ;
      endcase
    end
  end

  // Sizes above the build limits act as the limit
  always_comb begin
    cfg.ex = (32'(size_x) > MAX_COLS)   ? SizeW'(MAX_COLS)    : size_x;
    cfg.ey = (32'(size_y) > MAX_ROWS)   ? SizeW'(MAX_ROWS)    : size_y;
    cfg.ez = (32'(size_z) > MAX_LAYERS) ? SizeZW'(MAX_LAYERS) : size_z;
    cfg.cost_x     = cost_x;
    cfg.cost_y     = cost_y;
    cfg.cost_layer = cost_layer;
  end

endmodule

`default_nettype wire

// File: hdl/gcrc_cursor.sv
// Cursor state, opcode decode and first pipeline register.
`timescale 1ns / 1ps
`default_nettype none

`include "grid_cursor_and_route_cost_core_assert.svh"

module gcrc_cursor (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire gcrc_pkg::grid_cfg_t        cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0]                 opcode,
  input  wire logic [11:0]                coord_x,
  input  wire logic [11:0]                coord_y,
  input  wire logic [2:0]                 coord_z,
  input  wire logic signed [12:0]         step,
  output logic                            item_valid,
  output gcrc_pkg::cur_item_t             item,
  input  wire logic                       down_ready
);
  import gcrc_pkg::*;

  function automatic logic in_grid(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                                   input logic [LayerW-1:0] z, input grid_cfg_t c);
    return (x < c.ex) && (y < c.ey) && (z < c.ez);
  endfunction

  // Cursor state
  logic [CoordW-1:0] col, col_next;
  logic [CoordW-1:0] row, row_next;
  logic [LayerW-1:0] layer, layer_next;
  logic              ok, ok_next;

  logic              fire;
  logic [CoordW-1:0] tx, ty;
  logic [LayerW-1:0] tz;
  logic              live_now, tgt_in;
  logic signed [14:0] step_ext, nx, ny, nz;
  logic              x_fits, y_fits, z_fits;
  cur_item_t         item_next;

  always_comb begin
    in_ready = !item_valid || down_ready;
    fire     = in_valid && in_ready;
    tx       = {1'b0, coord_x};
    ty       = {1'b0, coord_y};
    tz       = {1'b0, coord_z};
    live_now = ok && in_grid(col, row, layer, cfg);
    tgt_in   = in_grid(tx, ty, tz, cfg);

    // Candidate moves along each axis
    step_ext = {{2{step[12]}}, step};
    nx       = $signed({2'b00, col}) + step_ext;
    ny       = $signed({2'b00, row}) + step_ext;
    nz       = $signed({11'd0, layer}) + step_ext;
    x_fits   = !nx[14] && (nx[13:0] < {1'b0, cfg.ex});
    y_fits   = !ny[14] && (ny[13:0] < {1'b0, cfg.ey});
    z_fits   = !nz[14] && (nz[13:0] < {10'd0, cfg.ez});

    // Next cursor
    col_next   = col;
    row_next   = row;
    layer_next = layer;
    ok_next    = ok;
    unique case (opcode)
      OP_SET: begin
        if (tgt_in) begin
          col_next   = tx;
          row_next   = ty;
          layer_next = tz;
          ok_next    = 1'b1;
        end else begin
          ok_next = 1'b0;
        end
      end
      OP_STEP_X: begin
        if (live_now && x_fits) col_next = nx[CoordW-1:0];
        else                    ok_next  = 1'b0;
      end
      OP_STEP_Y: begin
        if (live_now && y_fits) row_next = ny[CoordW-1:0];
        else                    ok_next  = 1'b0;
      end
      OP_STEP_Z: begin
        if (live_now && z_fits) layer_next = nz[LayerW-1:0];
        else                    ok_next    = 1'b0;
      end
      default: ;
    endcase

    // Item for the result stages
    item_next.live     = ok_next && in_grid(col_next, row_next, layer_next, cfg);
    item_next.col      = col_next;
    item_next.row      = row_next;
    item_next.layer    = layer_next;
    item_next.has_cost = (opcode == OP_DIST) && live_now && tgt_in;
    item_next.err      = (opcode == OP_DIST) && !(live_now && tgt_in);
    item_next.dx       = (col >= tx) ? col - tx : tx - col;
    item_next.dy       = (row >= ty) ? row - ty : ty - row;
    item_next.dz       = (layer >= tz) ? layer - tz : tz - layer;
    item_next.vias     = {1'b0, (layer == '0)} + {1'b0, (tz == '0)};
  end

  // Cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      layer <= '0;
      ok    <= 1'b0;
    end else if (fire) begin
      col   <= col_next;
      row   <= row_next;
      layer <= layer_next;
      ok    <= ok_next;
    end
  end

  // Stage one valid
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    if (fire) begin
      item <= item_next;
    end
  end

  `GCRC_ASSERT_NEXT(a_cursor_hold, clk, rst, !fire, $stable(col) && $stable(row) && $stable(layer) && $stable(ok), "cursor changed without an item")
  `GCRC_ASSERT_NEXT(a_invalid_sticks, clk, rst, fire && (opcode != OP_SET) && !ok, !ok, "invalid cursor revived without a set")
  `GCRC_ASSERT_NEXT(a_set_lands, clk, rst, fire && (opcode == OP_SET) && tgt_in, ok && (col == {1'b0, $past(coord_x)}), "set inside grid did not place cursor")

endmodule

`default_nettype wire

// File: hdl/gcrc_result.sv
// Index and cost arithmetic over two stages, ending in the output register.
`timescale 1ns / 1ps
`default_nettype none

`include "grid_cursor_and_route_cost_core_assert.svh"

module gcrc_result (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire gcrc_pkg::grid_cfg_t           cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire gcrc_pkg::cur_item_t           item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [gcrc_pkg::IndexW-1:0]        cursor_index,
  output logic                               cursor_valid,
  output logic [gcrc_pkg::CostW-1:0]         distance_cost,
  output logic                               error
);
  import gcrc_pkg::*;

  // Stage two: products
  logic                    mul_valid;
  logic                    mul_ready;
  logic                    live2, dist2, err2;
  logic [CoordW-1:0]       col2;
  logic [LayerW-1:0]       layer2;
  logic [2*SizeW-1:0]      row_ex;
  logic [2*SizeW-1:0]      ex_ey;
  logic [CoordW+WeightW-1:0] px, py;
  logic [LayerW+WeightW-1:0] pz;
  logic [WeightW+1:0]      via_cost;

  // Stage three: sums
  logic                    out_ready_int;
  logic [LayerW+2*SizeW-1:0] layer_term;
  logic [IndexW-1:0]       idx_sum;
  logic [CostSumW-1:0]     cost_sum;
  logic [CostW-1:0]        cost_sat;

  always_comb begin
    out_ready_int = !out_valid || out_ready;
    mul_ready     = !mul_valid || out_ready_int;
    in_ready      = mul_ready;
  end

  // Stage two valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= in_valid;
    end
  end

  // Stage two payload: one multiply per term
  always_ff @(posedge clk) begin
    if (in_valid && mul_ready) begin
      live2    <= item.live;
      dist2    <= item.has_cost;
      err2     <= item.err;
      col2     <= item.col;
      layer2   <= item.layer;
      row_ex   <= (2*SizeW)'(item.row) * (2*SizeW)'(cfg.ex);
      ex_ey    <= (2*SizeW)'(cfg.ex) * (2*SizeW)'(cfg.ey);
      px       <= (CoordW+WeightW)'(item.dx) * (CoordW+WeightW)'(cfg.cost_x);
      py       <= (CoordW+WeightW)'(item.dy) * (CoordW+WeightW)'(cfg.cost_y);
      pz       <= (LayerW+WeightW)'(item.dz) * (LayerW+WeightW)'(cfg.cost_layer);
      via_cost <= (WeightW+2)'(item.vias) * (WeightW+2)'(cfg.cost_layer);
    end
  end

  // Final index and saturated cost
  always_comb begin
    layer_term = (LayerW+2*SizeW)'(layer2) * (LayerW+2*SizeW)'(ex_ey);
    idx_sum    = IndexW'(col2) + IndexW'(row_ex) + layer_term[IndexW-1:0];
    cost_sum   = CostSumW'(px) + CostSumW'(py) + CostSumW'(pz) + CostSumW'(via_cost);
    cost_sat   = (cost_sum > CostSumW'(COST_SAT)) ? COST_SAT : cost_sum[CostW-1:0];
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready_int) begin
      out_valid <= mul_valid;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (mul_valid && out_ready_int) begin
      cursor_index  <= live2 ? idx_sum : '0;
      cursor_valid  <= live2;
      distance_cost <= dist2 ? cost_sat : '0;
      error         <= err2;
    end
  end

  `GCRC_ASSERT_NEXT(a_stage_advance, clk, rst, mul_valid && out_ready_int, out_valid, "stage two item dropped on its way out")
  `GCRC_ASSERT_NEXT(a_err_no_cost, clk, rst, mul_valid && out_ready_int && err2, error && (distance_cost == '0), "error result carries a cost")
  `GCRC_ASSERT_NOW(a_invalid_zero_index, clk, rst, out_valid && !cursor_valid, cursor_index == '0, "invalid cursor reported with an index")

endmodule

`default_nettype wire

// File: hdl/grid_cursor_and_route_cost_core.sv
// m_tvalid rises once an accepted item has passed the item, stage two and output
// registers. Throughput: one item per cycle while the output is not stalled; the cursor
// update (one add and bounds compare per axis) is combinational ahead of the item
// register, index and cost products sit in the two stages behind it.
// A stalled output stage backs up through the two item registers before input stalls.
// Reset (synchronous, rst high) clears the cursor to invalid, empties the pipeline and
// loads the register defaults: 4096 x 4096 x 8 grid, all weights 1.
`timescale 1ns / 1ps
`default_nettype none

module grid_cursor_and_route_cost_core #(
  parameter int MAX_COLS   = 4096,
  parameter int MAX_ROWS   = 4096,
  parameter int MAX_LAYERS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [12:0] cfg_data,
  // Input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // opcode[2:0], coord_x[14:3], coord_y[26:15],
                                      // coord_z[29:27], step[42:30], zero fill
  // Result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata    // cursor_index[26:0], cursor_valid[27],
                                      // distance_cost[48:28], error[49], zero fill
);
  import gcrc_pkg::*;

  grid_cfg_t         cfg;
  cur_item_t         item;
  logic              item_valid;
  logic              res_ready;
  logic [IndexW-1:0] cursor_index;
  logic              cursor_valid;
  logic [CostW-1:0]  distance_cost;
  logic              error;

  gcrc_cfg_regs #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_LAYERS (MAX_LAYERS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  gcrc_cursor u_cursor (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tdata[2:0]),
    .coord_x    (s_tdata[14:3]),
    .coord_y    (s_tdata[26:15]),
    .coord_z    (s_tdata[29:27]),
    .step       ($signed(s_tdata[42:30])),
    .item_valid (item_valid),
    .item       (item),
    .down_ready (res_ready)
  );

  gcrc_result u_result (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (item_valid),
    .in_ready      (res_ready),
    .item          (item),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .cursor_index  (cursor_index),
    .cursor_valid  (cursor_valid),
    .distance_cost (distance_cost),
    .error         (error)
  );

  assign m_tdata = {6'd0, error, distance_cost, cursor_valid, cursor_index};

endmodule

`default_nettype wire
